/* src/aps_pkg.sv */
// Shared types and constants for the archive path sanitizer.
`default_nettype none
package aps_pkg;

	// Characters of interest
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_COLON  = 8'h3a;
	localparam logic [7:0] CH_DOT    = 8'h2e;

	// Closing status / latched error codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FAIL   = 2'd1;
	localparam logic [1:0] ST_UNSAFE = 2'd2;

	localparam int CAP_W = 13;
	localparam logic [CAP_W-1:0] CAP_RESET = 13'd1024;

	// Descriptor queue depth between front and back
	localparam int QUEUE_DEPTH = 4;

	// One descriptor: 1..4 words, last one is the closing word when done is set
	typedef struct packed {
		logic [2:0]      cnt;
		logic            done;
		logic [1:0]      status;
		logic [3:0][7:0] bytes;
	} desc_t;

endpackage
`default_nettype wire

/* src/archive_path_sanitizer.sv */
// Top level of the archive path sanitizer.
// Each result word is written into the descriptor queue and read from there to the result ports.
// Throughput: one path byte per cycle unless full; one result word per pop, so
// a byte causing up to four words holds input once the descriptor queue fills.
// Reset: arst_n clears path state, queue and capacity (1024) at once.
`default_nettype none
module archive_path_sanitizer #(
	parameter int QUEUE_DEPTH = aps_pkg::QUEUE_DEPTH
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      push,
	output logic                           full,
	input  wire logic [7:0]                path_byte,
	output logic                           empty,
	input  wire logic                      pop,
	output logic [7:0]                     out_byte,
	output logic                           byte_valid,
	output logic                           path_done,
	output logic [1:0]                     status,
	output logic                           run_last,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [aps_pkg::CAP_W-1:0] cfg_data
);

	aps_pkg::desc_t desc, head;
	logic           desc_valid, head_rd, in_accept;

	assign cfg_ready = 1'b1;
	assign in_accept = push && !full;

	aps_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_accept  (in_accept),
		.path_byte  (path_byte),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_data   (cfg_data),
		.desc_valid (desc_valid),
		.desc       (desc)
	);

	aps_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (desc_valid),
		.wr_data (desc),
		.full    (full),
		.rd_en   (head_rd),
		.rd_data (head),
		.empty   (empty)
	);

	aps_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_empty (empty),
		.head_rd    (head_rd),
		.pop        (pop),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.path_done  (path_done),
		.status     (status),
		.run_last   (run_last)
	);

endmodule
`default_nettype wire

/* src/aps_front.sv */
// Front end: parses path bytes, tracks path state, builds output descriptors.
`default_nettype none
module aps_front (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_accept,
	input  wire logic [7:0]               path_byte,
	input  wire logic                     cfg_we,
	input  wire logic [aps_pkg::CAP_W-1:0] cfg_data,
	output logic                          desc_valid,
	output aps_pkg::desc_t                desc
);

	logic                      at_start_q;
	logic [1:0]                len_q;
	logic [7:0]                held_q [2];
	logic [aps_pkg::CAP_W-1:0] emit_q;
	logic                      colon_q;
	logic [1:0]                err_q;
	logic [aps_pkg::CAP_W-1:0] cap_q;

	logic                      at_start_n;
	logic [1:0]                len_n;
	logic [7:0]                held0_n, held1_n;
	logic [aps_pkg::CAP_W-1:0] emit_n;
	logic                      colon_n;
	logic [1:0]                err_n;

	logic is_zero, is_sep;
	logic cl_dotdot, cl_snd;
	logic [1:0] cl_k;
	logic snd, first, blocked, sep_b, over, ok_send;
	logic [1:0] k;
	logic [2:0] total, n;
	logic [7:0] c0, c1, c2;
	logic [aps_pkg::CAP_W:0] sum;

	assign is_zero = (path_byte == aps_pkg::CH_NUL);
	assign is_sep  = (path_byte == aps_pkg::CH_SLASH) || (path_byte == aps_pkg::CH_BSLASH);

	// component close: '.' dropped, '..' unsafe, else flushed
	assign cl_dotdot = (len_q == 2'd2) && (held_q[0] == aps_pkg::CH_DOT)
		&& (held_q[1] == aps_pkg::CH_DOT);
	assign cl_snd = ((len_q == 2'd1) && (held_q[0] != aps_pkg::CH_DOT))
		|| ((len_q == 2'd2) && !cl_dotdot);
	assign cl_k = (len_q == 2'd1) ? 2'd1 : 2'd2;

	// next state and descriptor for the current byte
	always_comb begin
		at_start_n = at_start_q;
		len_n      = len_q;
		held0_n    = held_q[0];
		held1_n    = held_q[1];
		colon_n    = colon_q;
		err_n      = err_q;
		snd        = 1'b0;
		first      = 1'b1;
		k          = 2'd0;
		c0         = held_q[0];
		c1         = held_q[1];
		c2         = path_byte;

		priority if (is_zero) begin
			if (!at_start_q) begin
				snd = cl_snd;
				k   = cl_k;
				if (cl_dotdot && err_n == aps_pkg::ST_OK)
					err_n = aps_pkg::ST_UNSAFE;
			end
		end else if (is_sep) begin
			if (at_start_q && err_n == aps_pkg::ST_OK)
				err_n = aps_pkg::ST_UNSAFE;
			at_start_n = 1'b0;
			snd        = cl_snd;
			k          = cl_k;
			if (cl_dotdot && err_n == aps_pkg::ST_OK)
				err_n = aps_pkg::ST_UNSAFE;
			len_n = 2'd0;
		end else begin
			at_start_n = 1'b0;
			if (path_byte == aps_pkg::CH_COLON)
				colon_n = 1'b1;
			priority if (len_q == 2'd0) begin
				held0_n = path_byte;
				len_n   = 2'd1;
			end else if (len_q == 2'd1) begin
				held1_n = path_byte;
				len_n   = 2'd2;
			end else if (len_q == 2'd2) begin
				snd   = 1'b1;
				k     = 2'd3;
				len_n = 2'd3;
			end else begin
				snd   = 1'b1;
				k     = 2'd1;
				first = 1'b0;
				c0    = path_byte;
			end
		end

		// capacity check and chunk send
		blocked = colon_n || (err_n != aps_pkg::ST_OK);
		sep_b   = first && (emit_q != '0);
		total   = {1'b0, k} + {2'b0, sep_b};
		sum     = {1'b0, emit_q} + {{(aps_pkg::CAP_W-2){1'b0}}, total};
		over    = (sum >= {1'b0, cap_q});
		ok_send = 1'b0;
		emit_n  = emit_q;
		if (snd && !blocked) begin
			if (over)
				err_n = aps_pkg::ST_FAIL;
			else begin
				ok_send = 1'b1;
				emit_n  = sum[aps_pkg::CAP_W-1:0];
			end
		end
		n = ok_send ? total : 3'd0;

		desc.bytes  = '0;
		desc.done   = is_zero;
		desc.status = aps_pkg::ST_OK;
		if (sep_b) begin
			desc.bytes[0] = aps_pkg::CH_SLASH;
			desc.bytes[1] = c0;
			desc.bytes[2] = c1;
			desc.bytes[3] = c2;
		end else begin
			desc.bytes[0] = c0;
			desc.bytes[1] = c1;
			desc.bytes[2] = c2;
		end

		// closing word sits after the chunk
		if (is_zero) begin
			desc.cnt = n + 3'd1;
			priority if (at_start_q)
				desc.status = aps_pkg::ST_FAIL;
			else if (colon_n)
				desc.status = aps_pkg::ST_UNSAFE;
			else if (err_n != aps_pkg::ST_OK)
				desc.status = err_n;
			else if (emit_n == '0)
				desc.status = aps_pkg::ST_FAIL;
			else
				desc.status = aps_pkg::ST_OK;
		end else begin
			desc.cnt = n;
		end
	end

	assign desc_valid = in_accept && (desc.cnt != 3'd0);

	// path state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q <= 1'b1;
			len_q      <= 2'd0;
			emit_q     <= '0;
			colon_q    <= 1'b0;
			err_q      <= aps_pkg::ST_OK;
		end else if (in_accept) begin
			if (is_zero) begin
				at_start_q <= 1'b1;
				len_q      <= 2'd0;
				emit_q     <= '0;
				colon_q    <= 1'b0;
				err_q      <= aps_pkg::ST_OK;
			end else begin
				at_start_q <= at_start_n;
				len_q      <= len_n;
				emit_q     <= emit_n;
				colon_q    <= colon_n;
				err_q      <= err_n;
			end
		end
	end

	// held component bytes, no reset needed
	always_ff @(posedge clk) begin
		if (in_accept) begin
			held_q[0] <= held0_n;
			held_q[1] <= held1_n;
		end
	end

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cap_q <= aps_pkg::CAP_RESET;
		else if (cfg_we)
			cap_q <= cfg_data;
	end

endmodule
`default_nettype wire

/* src/aps_queue.sv */
// Small descriptor queue between the front and back ends.
`default_nettype none
module aps_queue #(
	parameter int DEPTH = aps_pkg::QUEUE_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr_en,
	input  aps_pkg::desc_t      wr_data,
	output logic                full,
	input  wire logic           rd_en,
	output aps_pkg::desc_t      rd_data,
	output logic                empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	aps_pkg::desc_t mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  cnt_q;
	logic           do_wr, do_rd;

	assign full    = (cnt_q == FULL_CNT);
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + AW'(1);
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + AW'(1);
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + CW'(1);
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule
`default_nettype wire

/* src/aps_back.sv */
// Back end: walks the head descriptor one word per pop.
`default_nettype none
module aps_back (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  aps_pkg::desc_t head,
	input  wire logic      head_empty,
	output logic           head_rd,
	input  wire logic      pop,
	output logic [7:0]     out_byte,
	output logic           byte_valid,
	output logic           path_done,
	output logic [1:0]     status,
	output logic           run_last
);

	logic [1:0] idx_q;
	logic       last, is_close;

	assign last     = ({1'b0, idx_q} + 3'd1) == head.cnt;
	assign is_close = head.done && last;

	// current word
	assign out_byte   = is_close ? aps_pkg::CH_NUL : head.bytes[idx_q];
	assign byte_valid = !is_close;
	assign path_done  = is_close;
	assign status     = is_close ? head.status : aps_pkg::ST_OK;
	assign run_last   = last;

	assign head_rd = pop && !head_empty && last;

	// word index within the head descriptor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idx_q <= 2'd0;
		else if (pop && !head_empty)
			idx_q <= last ? 2'd0 : idx_q + 2'd1;
	end

endmodule
`default_nettype wire
